[design/selective_repeat_sender_window_defines.svh]
// assertion helpers, sampled on clk and held off while rst_n is low
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SRSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/srsw_pkg.sv]
package srsw_pkg;

  localparam int CMD_W     = 2;
  localparam int SEQ_W     = 3;
  localparam int PAYLOAD_W = 64;
  localparam int WIN_W     = 3;

  // window size after reset
  localparam int WIN_RESET = 4;

  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic slide;     // try to move the base past one acked slot
    logic load_out;  // publish the finished result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mark_at_base;  // slot at the base is acked
    logic out_free;      // output register can take a result
  } ctl_stat_t;

endpackage

[design/srsw_ram.sv]
module srsw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/srsw_ctrl.sv]
`include "selective_repeat_sender_window_defines.svh"

module srsw_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [srsw_pkg::CMD_W-1:0]    in_command,
  output logic                          in_stall,
  output logic                          cfg_ready,
  output srsw_pkg::ctl_cmd_t            cmd,
  input  srsw_pkg::ctl_stat_t           stat
);

  import srsw_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SLIDE = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_command == CMD_ACK) ? ST_SLIDE : ST_FIN;
        end
      end
      ST_SLIDE: begin
        cmd.slide = 1'b1;
        if (!stat.mark_at_base) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SRSW_ASSERT_NEXT(a_busy_after_accept, cmd.accept, in_stall, "input taken while item in flight")

endmodule

[design/srsw_dpath.sv]
`include "selective_repeat_sender_window_defines.svh"

module srsw_dpath #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srsw_pkg::ctl_cmd_t                cmd,
  output srsw_pkg::ctl_stat_t               stat,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [srsw_pkg::WIN_W-1:0]        cfg_window_size,
  input  logic [srsw_pkg::CMD_W-1:0]        in_command,
  input  logic [srsw_pkg::PAYLOAD_W-1:0]    in_payload,
  input  logic [srsw_pkg::SEQ_W-1:0]        in_seq_num,
  input  logic                              in_ack_ok,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              out_emit_packet,
  output logic [srsw_pkg::SEQ_W-1:0]        out_packet_seq,
  output logic [srsw_pkg::PAYLOAD_W-1:0]    out_packet_payload,
  output logic                              out_start_timer,
  output logic                              out_stop_timer,
  output logic [srsw_pkg::SEQ_W-1:0]        out_timer_seq,
  output logic                              out_send_refused,
  output logic [srsw_pkg::SEQ_W-1:0]        out_window_base,
  output logic [srsw_pkg::SEQ_W-1:0]        out_next_sequence
);

  import srsw_pkg::*;

  localparam int SW = $clog2(SEQ_SPACE);
  localparam int EW = ((SW > WIN_W) ? SW : WIN_W) + 1;
  localparam int SQ = ((SW > SEQ_W) ? SW : SEQ_W) + 1;
  localparam logic [SW:0]   SS_W   = (SW+1)'(SEQ_SPACE);
  localparam logic [EW-1:0] SS_E   = EW'(SEQ_SPACE);
  localparam logic [SQ-1:0] SS_Q   = SQ'(SEQ_SPACE);
  localparam logic [SW-1:0] SEQ_LAST = SW'(SEQ_SPACE - 1);
  localparam int WR = (WIN_RESET >= SEQ_SPACE) ? SEQ_SPACE - 1 : WIN_RESET;
  localparam logic [SW-1:0] WIN_RST = SW'(WR);

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
    seq_inc = (s == SEQ_LAST) ? '0 : s + 1'b1;
  endfunction

  // state
  logic [SW-1:0]           win_r, win_nxt;
  logic [SW-1:0]           base_r, base_nxt;
  logic [SW-1:0]           next_r, next_nxt;
  logic [SEQ_SPACE-1:0]    marks_r, marks_nxt;

  // item in flight
  logic                    pend_emit_r, pend_emit_nxt;
  logic                    pend_start_r, pend_start_nxt;
  logic                    pend_stop_r, pend_stop_nxt;
  logic                    pend_refused_r, pend_refused_nxt;
  logic                    pend_ram_r, pend_ram_nxt;
  logic [SW-1:0]           pend_seq_r, pend_seq_nxt;
  logic [PAYLOAD_BITS-1:0] pend_pay_r, pend_pay_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic                    emit_r, emit_nxt;
  logic [SEQ_W-1:0]        pseq_r, pseq_nxt;
  logic [PAYLOAD_W-1:0]    ppay_r, ppay_nxt;
  logic                    start_r, start_nxt;
  logic                    stop_r, stop_nxt;
  logic [SEQ_W-1:0]        tseq_r, tseq_nxt;
  logic                    refused_r, refused_nxt;
  logic [SEQ_W-1:0]        wbase_r, wbase_nxt;
  logic [SEQ_W-1:0]        wnext_r, wnext_nxt;

  // decode
  logic [EW-1:0]           cfg_w_e;
  logic [SW-1:0]           win_clamped;
  logic [SQ-1:0]           seq_e;
  logic                    seq_ok;
  logic [SW-1:0]           seq_idx;
  logic [SW:0]             end_sum;
  logic [SW:0]             end_dif;
  logic [SW-1:0]           end_seq;
  logic [SW:0]             seq_off;
  logic                    in_win;

  // ram
  logic                    ram_we;
  logic                    ram_re;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  always_comb begin
    cfg_w_e = EW'(cfg_window_size);
    if (cfg_w_e == '0) begin
      win_clamped = SW'(1);
    end else if (cfg_w_e >= SS_E) begin
      win_clamped = SEQ_LAST;
    end else begin
      win_clamped = cfg_w_e[SW-1:0];
    end
  end

  assign seq_e   = SQ'(in_seq_num);
  assign seq_ok  = (seq_e < SS_Q);
  assign seq_idx = seq_e[SW-1:0];

  assign end_sum = {1'b0, base_r} + {1'b0, win_r};
  assign end_dif = end_sum - SS_W;
  assign end_seq = (end_sum >= SS_W) ? end_dif[SW-1:0] : end_sum[SW-1:0];

  assign seq_off = (seq_idx >= base_r) ? ({1'b0, seq_idx} - {1'b0, base_r})
                                       : ({1'b0, seq_idx} + SS_W - {1'b0, base_r});
  assign in_win  = (seq_off < {1'b0, win_r});

  always_comb begin
    win_nxt          = win_r;
    base_nxt         = base_r;
    next_nxt         = next_r;
    marks_nxt        = marks_r;
    pend_emit_nxt    = pend_emit_r;
    pend_start_nxt   = pend_start_r;
    pend_stop_nxt    = pend_stop_r;
    pend_refused_nxt = pend_refused_r;
    pend_ram_nxt     = pend_ram_r;
    pend_seq_nxt     = pend_seq_r;
    pend_pay_nxt     = pend_pay_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;

    if (cfg_valid && cfg_ready) begin
      win_nxt = win_clamped;
    end

    if (cmd.accept) begin
      pend_emit_nxt    = 1'b0;
      pend_start_nxt   = 1'b0;
      pend_stop_nxt    = 1'b0;
      pend_refused_nxt = 1'b0;
      pend_ram_nxt     = 1'b0;
      pend_seq_nxt     = seq_idx;
      pend_pay_nxt     = in_payload[PAYLOAD_BITS-1:0];
      case (in_command)
        CMD_SEND: begin
          if (end_seq == next_r) begin
            pend_refused_nxt = 1'b1;
          end else begin
            ram_we         = 1'b1;
            pend_emit_nxt  = 1'b1;
            pend_start_nxt = 1'b1;
            pend_seq_nxt   = next_r;
            next_nxt       = seq_inc(next_r);
          end
        end
        CMD_ACK: begin
          if (in_ack_ok && seq_ok) begin
            pend_stop_nxt = 1'b1;
            if (in_win) begin
              marks_nxt[seq_idx] = 1'b1;
            end
          end
        end
        CMD_TIMEOUT: begin
          if (seq_ok) begin
            ram_re         = 1'b1;
            pend_emit_nxt  = 1'b1;
            pend_start_nxt = 1'b1;
            pend_ram_nxt   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.slide && marks_r[base_r]) begin
      marks_nxt[base_r] = 1'b0;
      base_nxt          = seq_inc(base_r);
    end
  end

  srsw_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SEQ_SPACE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_r),
    .wdata (in_payload[PAYLOAD_BITS-1:0]),
    .re    (ram_re),
    .raddr (seq_idx),
    .rdata (ram_rdata)
  );

  assign stat.mark_at_base = marks_r[base_r];
  assign stat.out_free     = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    emit_nxt      = emit_r;
    pseq_nxt      = pseq_r;
    ppay_nxt      = ppay_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    tseq_nxt      = tseq_r;
    refused_nxt   = refused_r;
    wbase_nxt     = wbase_r;
    wnext_nxt     = wnext_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      emit_nxt      = pend_emit_r;
      pseq_nxt      = pend_emit_r ? SEQ_W'(pend_seq_r) : '0;
      if (!pend_emit_r) begin
        ppay_nxt = '0;
      end else if (pend_ram_r) begin
        ppay_nxt = PAYLOAD_W'(ram_rdata);
      end else begin
        ppay_nxt = PAYLOAD_W'(pend_pay_r);
      end
      start_nxt   = pend_start_r;
      stop_nxt    = pend_stop_r;
      tseq_nxt    = (pend_start_r || pend_stop_r) ? SEQ_W'(pend_seq_r) : '0;
      refused_nxt = pend_refused_r;
      wbase_nxt   = SEQ_W'(base_r);
      wnext_nxt   = SEQ_W'(next_r);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_RST;
      base_r      <= SW'(1);
      next_r      <= SW'(1);
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_emit_r    <= pend_emit_nxt;
    pend_start_r   <= pend_start_nxt;
    pend_stop_r    <= pend_stop_nxt;
    pend_refused_r <= pend_refused_nxt;
    pend_ram_r     <= pend_ram_nxt;
    pend_seq_r     <= pend_seq_nxt;
    pend_pay_r     <= pend_pay_nxt;
    emit_r         <= emit_nxt;
    pseq_r         <= pseq_nxt;
    ppay_r         <= ppay_nxt;
    start_r        <= start_nxt;
    stop_r         <= stop_nxt;
    tseq_r         <= tseq_nxt;
    refused_r      <= refused_nxt;
    wbase_r        <= wbase_nxt;
    wnext_r        <= wnext_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_emit_packet    = emit_r;
  assign out_packet_seq     = pseq_r;
  assign out_packet_payload = ppay_r;
  assign out_start_timer    = start_r;
  assign out_stop_timer     = stop_r;
  assign out_timer_seq      = tseq_r;
  assign out_send_refused   = refused_r;
  assign out_window_base    = wbase_r;
  assign out_next_sequence  = wnext_r;

  `SRSW_ASSERT_NOW(a_base_settled, cmd.load_out, !stat.mark_at_base, "base not settled")
  `SRSW_ASSERT_NOW(a_out_from_load, $rose(out_valid_r), $past(cmd.load_out), "valid without load")

endmodule

[design/selective_repeat_sender_window.sv]
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  command, payload, seq_num, ack_ok
// out_      output     out_valid/out_stall  emit, seq, payload, timers, refused, base, next
// cfg_      input      cfg_valid/cfg_ready  window_size
//
// send and timeout beats go from accept to the publish state and then back to idle
// an ack beat first slides the base past the acked slots, then goes to the publish state;
// the base moves one slot a cycle in the controller's slide state
// the timeout payload comes from the packet store's registered read port
// rst_n is synchronous: base and next sequence go to 1, acked marks clear, window 4
// a stalled output holds the finished result; the next input beat is still taken
`include "selective_repeat_sender_window_defines.svh"

module selective_repeat_sender_window #(
  parameter int SEQ_SPACE    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srsw_pkg::WIN_W-1:0]        cfg_window_size,
  // input beats
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [srsw_pkg::CMD_W-1:0]        in_command,
  input  logic [srsw_pkg::PAYLOAD_W-1:0]    in_payload,
  input  logic [srsw_pkg::SEQ_W-1:0]        in_seq_num,
  input  logic                              in_ack_ok,
  // result beats
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_emit_packet,
  output logic [srsw_pkg::SEQ_W-1:0]        out_packet_seq,
  output logic [srsw_pkg::PAYLOAD_W-1:0]    out_packet_payload,
  output logic                              out_start_timer,
  output logic                              out_stop_timer,
  output logic [srsw_pkg::SEQ_W-1:0]        out_timer_seq,
  output logic                              out_send_refused,
  output logic [srsw_pkg::SEQ_W-1:0]        out_window_base,
  output logic [srsw_pkg::SEQ_W-1:0]        out_next_sequence
);

  import srsw_pkg::*;

  // command and status between sequencer and datapath
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // sequencer: idle, slide the base, publish the result
  srsw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // window state, acked marks, packet store and output register
  srsw_dpath #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_window_size    (cfg_window_size),
    .in_command         (in_command),
    .in_payload         (in_payload),
    .in_seq_num         (in_seq_num),
    .in_ack_ok          (in_ack_ok),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_emit_packet    (out_emit_packet),
    .out_packet_seq     (out_packet_seq),
    .out_packet_payload (out_packet_payload),
    .out_start_timer    (out_start_timer),
    .out_stop_timer     (out_stop_timer),
    .out_timer_seq      (out_timer_seq),
    .out_send_refused   (out_send_refused),
    .out_window_base    (out_window_base),
    .out_next_sequence  (out_next_sequence)
  );

  // a slide or publish step never coincides with taking a new beat
  `SRSW_ASSERT_NOW(a_one_step, cmd.accept, !cmd.slide && !cmd.load_out, "accept overlaps item work")

endmodule

[tb/testbench.sv]
module testbench;
  import srsw_pkg::*;

  // the package names three commands; the fourth code does nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RING = 8;
  localparam int PHASE_BEATS = 60;
  localparam int LONG_HOLD = 150;
  localparam int SETTLE_CYCLES = 16;

  // one input beat
  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     seq_num;
    logic                 ack_ok;
  } sender_cmd_t;

  // one result beat, fields in port order
  typedef struct packed {
    logic                 emit_packet;
    logic [SEQ_W-1:0]     packet_seq;
    logic [PAYLOAD_W-1:0] packet_payload;
    logic                 start_timer;
    logic                 stop_timer;
    logic [SEQ_W-1:0]     timer_seq;
    logic                 send_refused;
    logic [SEQ_W-1:0]     window_base;
    logic [SEQ_W-1:0]     next_sequence;
  } packet_report_t;

  // tracks the sender window and the reports it still owes
  class arq_sender_tracker;
    logic [WIN_W-1:0]     window_reg;
    logic [SEQ_W-1:0]     base_seq;
    logic [SEQ_W-1:0]     next_seq;
    bit                   acked [RING];
    bit                   written [RING];
    logic [PAYLOAD_W-1:0] stored [RING];
    packet_report_t       owed_reports [$];
    int                   errors;

    function void reset_state();
      window_reg = WIN_W'(WIN_RESET);
      base_seq = SEQ_W'(1);
      next_seq = SEQ_W'(1);
      errors = 0;
      for (int i = 0; i < RING; i++) begin
        acked[i] = 1'b0;
        written[i] = 1'b0;
        stored[i] = '0;
      end
    endfunction

    function void set_window(logic [WIN_W-1:0] w);
      window_reg = w;
    endfunction

    // a zero setting still opens one slot; seven is already the ring limit
    function logic [SEQ_W-1:0] open_slots();
      return (window_reg == 0) ? SEQ_W'(1) : window_reg;
    endfunction

    function int in_flight();
      logic [SEQ_W-1:0] span;
      span = next_seq - base_seq;
      return int'(span);
    endfunction

    // applies one beat to the window and returns the report it produces
    function packet_report_t advance_window(sender_cmd_t c);
      packet_report_t r;
      logic [SEQ_W-1:0] ring_end;
      logic [SEQ_W-1:0] seq_off;
      r = '0;
      case (c.command)
        CMD_SEND: begin
          ring_end = base_seq + open_slots();
          if (ring_end == next_seq) begin
            r.send_refused = 1'b1;
          end else begin
            stored[next_seq] = c.payload;
            written[next_seq] = 1'b1;
            r.emit_packet = 1'b1;
            r.packet_seq = next_seq;
            r.packet_payload = c.payload;
            r.start_timer = 1'b1;
            r.timer_seq = next_seq;
            next_seq = next_seq + 1'b1;
          end
        end
        CMD_ACK: begin
          if (c.ack_ok) begin
            r.stop_timer = 1'b1;
            r.timer_seq = c.seq_num;
            seq_off = c.seq_num - base_seq;
            if (seq_off < open_slots()) begin
              acked[c.seq_num] = 1'b1;
              for (int n = 0; n < RING && acked[base_seq]; n++) begin
                acked[base_seq] = 1'b0;
                base_seq = base_seq + 1'b1;
              end
            end
          end
        end
        CMD_TIMEOUT: begin
          r.emit_packet = 1'b1;
          r.packet_seq = c.seq_num;
          r.packet_payload = stored[c.seq_num];
          r.start_timer = 1'b1;
          r.timer_seq = c.seq_num;
        end
        default: begin
        end
      endcase
      r.window_base = base_seq;
      r.next_sequence = next_seq;
      return r;
    endfunction

    function void take_command(sender_cmd_t c);
      owed_reports.push_back(advance_window(c));
    endfunction

    function void match_field(string field, logic [PAYLOAD_W-1:0] want,
                              logic [PAYLOAD_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_packet_report(packet_report_t got);
      packet_report_t want;
      if (owed_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      match_field("emit_packet", PAYLOAD_W'(want.emit_packet), PAYLOAD_W'(got.emit_packet));
      match_field("packet_seq", PAYLOAD_W'(want.packet_seq), PAYLOAD_W'(got.packet_seq));
      match_field("packet_payload", want.packet_payload, got.packet_payload);
      match_field("start_timer", PAYLOAD_W'(want.start_timer), PAYLOAD_W'(got.start_timer));
      match_field("stop_timer", PAYLOAD_W'(want.stop_timer), PAYLOAD_W'(got.stop_timer));
      match_field("timer_seq", PAYLOAD_W'(want.timer_seq), PAYLOAD_W'(got.timer_seq));
      match_field("send_refused", PAYLOAD_W'(want.send_refused),
                  PAYLOAD_W'(got.send_refused));
      match_field("window_base", PAYLOAD_W'(want.window_base), PAYLOAD_W'(got.window_base));
      match_field("next_sequence", PAYLOAD_W'(want.next_sequence),
                  PAYLOAD_W'(got.next_sequence));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WIN_W-1:0]     cfg_window_size = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = '0;
  logic [PAYLOAD_W-1:0] in_payload = '0;
  logic [SEQ_W-1:0]     in_seq_num = '0;
  logic                 in_ack_ok = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_emit_packet;
  logic [SEQ_W-1:0]     out_packet_seq;
  logic [PAYLOAD_W-1:0] out_packet_payload;
  logic                 out_start_timer;
  logic                 out_stop_timer;
  logic [SEQ_W-1:0]     out_timer_seq;
  logic                 out_send_refused;
  logic [SEQ_W-1:0]     out_window_base;
  logic [SEQ_W-1:0]     out_next_sequence;

  arq_sender_tracker sb;

  // idling switches, changed per phase by the main sequence
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  // long receiver hold-offs asked for so far, counted by the main sequence
  int hold_requests = 0;

  packet_report_t seen_report;

  selective_repeat_sender_window uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_window_size    (cfg_window_size),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_payload         (in_payload),
    .in_seq_num         (in_seq_num),
    .in_ack_ok          (in_ack_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_emit_packet    (out_emit_packet),
    .out_packet_seq     (out_packet_seq),
    .out_packet_payload (out_packet_payload),
    .out_start_timer    (out_start_timer),
    .out_stop_timer     (out_stop_timer),
    .out_timer_seq      (out_timer_seq),
    .out_send_refused   (out_send_refused),
    .out_window_base    (out_window_base),
    .out_next_sequence  (out_next_sequence)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  // exactly one assignment to out_stall per falling edge
  initial begin
    int stall_left;
    int holds_taken;
    stall_left = 0;
    holds_taken = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (holds_taken != hold_requests) begin
          holds_taken = hold_requests;
          stall_left = LONG_HOLD;
        end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 18);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor: a beat moves when valid is high and stall is low
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      seen_report = {out_emit_packet, out_packet_seq, out_packet_payload, out_start_timer,
                     out_stop_timer, out_timer_seq, out_send_refused, out_window_base,
                     out_next_sequence};
      sb.check_packet_report(seen_report);
    end
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  // offers one beat, with an optional random gap first, and waits for it to be taken
  task automatic drive_beat(input sender_cmd_t c);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= c.command;
    in_payload <= c.payload;
    in_seq_num <= c.seq_num;
    in_ack_ok  <= c.ack_ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_command(c);
  endtask

  task automatic directed_beat(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                               input logic ok, input logic [PAYLOAD_W-1:0] pay);
    sender_cmd_t c;
    c.command = cmd;
    c.payload = pay;
    c.seq_num = seq;
    c.ack_ok = ok;
    drive_beat(c);
  endtask

  // drop valid right after the last accepted beat, then wait for every report
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.owed_reports.size() != 0) @(posedge clk);
    // an ack that slides the base may still be busy inside the block
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_window_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_window(w);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly protocol-correct traffic: sends, acks of packets in flight, timeouts
  // on stored packets; the rest is corrupt or stray acks and the unused code
  function automatic sender_cmd_t next_random_cmd();
    sender_cmd_t c;
    int pick;
    int flight;
    c.command = CMD_SEND;
    c.payload = rand_payload();
    c.seq_num = SEQ_W'($urandom_range(0, RING - 1));
    c.ack_ok = 1'($urandom_range(0, 1));
    flight = sb.in_flight();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      c.command = CMD_SEND;
    end else if (pick < 75) begin
      if (flight != 0) begin
        c.command = CMD_ACK;
        c.ack_ok = 1'b1;
        c.seq_num = sb.base_seq + SEQ_W'($urandom_range(0, flight - 1));
      end
    end else if (pick < 85) begin
      c.command = CMD_TIMEOUT;
      if (flight != 0 && $urandom_range(0, 3) != 0) begin
        c.seq_num = sb.base_seq + SEQ_W'($urandom_range(0, flight - 1));
      end
    end else begin
      case ($urandom_range(0, 3))
        0: c.command = CMD_ACK;
        1: begin
          c.command = CMD_ACK;
          c.ack_ok = 1'b0;
        end
        2: c.command = CMD_UNUSED;
        default: c.command = CMD_TIMEOUT;
      endcase
    end
    // never time out a slot that was never filled
    if (c.command == CMD_TIMEOUT && !sb.written[c.seq_num]) begin
      c.command = CMD_SEND;
    end
    return c;
  endfunction

  initial begin
    int window_plan [9];
    window_plan = '{7, 0, 1, 5, 2, 6, 3, 4, 7};
    sb = new;
    sb.reset_state();

    // synchronous reset, released on a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset window of four, base and next at one
    directed_beat(CMD_SEND, 3'd0, 1'b0, '0);
    directed_beat(CMD_SEND, 3'd7, 1'b1, '1);
    directed_beat(CMD_SEND, 3'd5, 1'b1, rand_payload());
    directed_beat(CMD_SEND, 3'd2, 1'b0, rand_payload());
    // window full
    directed_beat(CMD_SEND, 3'd1, 1'b1, rand_payload());
    // unused command code
    directed_beat(CMD_UNUSED, 3'd7, 1'b1, '1);
    directed_beat(CMD_TIMEOUT, 3'd2, 1'b0, rand_payload());
    // corrupt ack
    directed_beat(CMD_ACK, 3'd1, 1'b0, rand_payload());
    // ack above the base is only marked
    directed_beat(CMD_ACK, 3'd3, 1'b1, rand_payload());
    // ack outside the window only stops the timer
    directed_beat(CMD_ACK, 3'd7, 1'b1, rand_payload());
    directed_beat(CMD_ACK, 3'd1, 1'b1, rand_payload());
    // base slides over two marked slots
    directed_beat(CMD_ACK, 3'd2, 1'b1, rand_payload());
    // timeout on an acked slot still resends
    directed_beat(CMD_TIMEOUT, 3'd3, 1'b1, '0);
    directed_beat(CMD_ACK, 3'd4, 1'b1, '1);
    // fill the window across the wrap, last one refused
    repeat (5) directed_beat(CMD_SEND, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             rand_payload());
    directed_beat(CMD_TIMEOUT, 3'd0, 1'b0, rand_payload());
    directed_beat(CMD_ACK, 3'd6, 1'b1, rand_payload());
    directed_beat(CMD_ACK, 3'd5, 1'b1, rand_payload());
    directed_beat(CMD_ACK, 3'd0, 1'b1, rand_payload());
    // base wraps from seven back to one
    directed_beat(CMD_ACK, 3'd7, 1'b1, rand_payload());

    // random phases, one window setting each; the last runs with no idling
    for (int p = 0; p < 9; p++) begin
      settle();
      write_window(WIN_W'(window_plan[p]));
      send_gaps = (p == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_gaps = (p == 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
      // long receiver hold-off so the block backs up into the input
      if (p == 1) hold_requests++;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        drive_beat(next_random_cmd());
      end
    end
    settle();

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
